>>> sv/assert_macros.svh
// Assertion macros shared by the clipper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> sv/pscc_pkg.sv
// Package with widths, constants and the sequencer states of the cube clipper.
package pscc_pkg;
	localparam int FRAC_BITS = 16;
	localparam int COORD_BITS = 24;
	localparam int OUT_BITS = 18;
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int CNT_BITS = $clog2(DW);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DW - 1);
	localparam logic signed [COORD_BITS-1:0] ONE_FX = COORD_BITS'(1 << FRAC_BITS);
	localparam logic [2:0] PLANE_LAST = 3'd5;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [OUT_BITS-1:0] out_coord_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PLANE,
		ST_SEL,
		ST_MUL,
		ST_DIV,
		ST_RND,
		ST_WR,
		ST_OUT_A,
		ST_OUT_B
	} state_t;
endpackage

>>> sv/pscc_vtx_if.sv
// Vertex input channel and clipped point output channel.
interface pscc_vtx_if import pscc_pkg::*; ();
	logic valid;
	logic ready;
	coord_t vert_x;
	coord_t vert_y;
	coord_t vert_z;
	logic strip_start;
	modport source(output valid, vert_x, vert_y, vert_z, strip_start, input ready);
	modport sink(input valid, vert_x, vert_y, vert_z, strip_start, output ready);
endinterface

interface pscc_pt_if import pscc_pkg::*; ();
	logic valid;
	logic ready;
	out_coord_t out_x;
	out_coord_t out_y;
	out_coord_t out_z;
	logic segment_end;
	modport source(output valid, out_x, out_y, out_z, segment_end, input ready);
	modport sink(input valid, out_x, out_y, out_z, segment_end, output ready);
endinterface

>>> sv/polyline_segment_clip_cube.sv
// Top level: clips polyline segments to the unit cube with a bit-serial multiply-divide.
//
//  channel    | dir | beat
//  vtx        | in  | one vertex x, y, z and strip_start
//  pt         | out | one clipped endpoint, segment_end on the second
//  lines_mode | in  | write enable and one data bit
//
// A vertex that forms no segment is only stored as the previous vertex. A segment is accepted,
// each plane is examined in turn and, for each plane that cuts it, the two other coordinates
// pass through the shared shift-add multiplier and restoring divider; then 2 output beats follow.
// A segment that lies wholly outside one plane is dropped with no output beats.
// One vertex is handled at a time; vtx.ready is high only when the sequencer is idle.
// Output beats hold while pt.ready is low. Reset clears the control state and the stored previous vertex only.
`include "assert_macros.svh"
module polyline_segment_clip_cube import pscc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic lines_mode_we,
	input logic lines_mode_wdata,
	pscc_vtx_if.sink vtx,
	pscc_pt_if.source pt
);
	state_t state_q, state_d;
	logic lines_mode_q, have_prev_q;
	coord_t prev_q [3];
	coord_t a_q [3];
	coord_t b_q [3];
	coord_t tmp_q [3];
	logic [2:0] plane_q;
	logic [1:0] j_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic ina_q, dneg_q;
	logic [DW-1:0] num_q, den_q, mcand_q, nsh_q, low_q;
	logic [PW-1:0] prod_q;
	logic [DW:0] rem_q;

	function automatic coord_t pick(input coord_t v0, v1, v2, input logic [1:0] idx);
		coord_t r;
		case (idx)
			2'd0: r = v0;
			2'd1: r = v1;
			default: r = v2;
		endcase
		return r;
	endfunction

	logic [1:0] axis;
	logic lower, ina, inb, accept, form;
	coord_t bound, ak, bk, aj, bj;
	logic signed [DW:0] n0, d0, dj;
	logic [PW-1:0] prod_nx;
	logic [DW:0] trial;
	logic [DW:0] q_rnd;
	logic signed [DW+1:0] res_j;

	always_comb begin
		axis = plane_q[2:1];
		lower = ~plane_q[0];
		bound = lower ? -ONE_FX : ONE_FX;
		ak = pick(a_q[0], a_q[1], a_q[2], axis);
		bk = pick(b_q[0], b_q[1], b_q[2], axis);
		aj = pick(a_q[0], a_q[1], a_q[2], j_q);
		bj = pick(b_q[0], b_q[1], b_q[2], j_q);
		ina = lower ? (ak >= bound) : (ak <= bound);
		inb = lower ? (bk >= bound) : (bk <= bound);
		n0 = (DW+1)'(bound) - (DW+1)'(ak);
		d0 = (DW+1)'(bk) - (DW+1)'(ak);
		if (d0 < 0) begin
			n0 = -n0;
			d0 = -d0;
		end
		dj = (DW+1)'(bj) - (DW+1)'(aj);
		prod_nx = {prod_q[PW-2:0], 1'b0} + (nsh_q[DW-1] ? PW'(mcand_q) : '0);
		trial = {rem_q[DW-1:0], low_q[DW-1]};
		q_rnd = (DW+1)'(low_q) + (DW+1)'(({rem_q, 1'b0}) >= (DW+2)'(den_q));
		res_j = dneg_q ? ((DW+2)'(aj) - (DW+2)'(q_rnd)) : ((DW+2)'(aj) + (DW+2)'(q_rnd));
		accept = vtx.valid && vtx.ready;
		form = have_prev_q && !vtx.strip_start && lines_mode_q;
	end

	always_comb begin
		state_d = state_q;
		vtx.ready = 1'b0;
		pt.valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				vtx.ready = 1'b1;
				if (vtx.valid && form) begin
					state_d = ST_PLANE;
				end
			end
			ST_PLANE: begin
				if (ina && inb) begin
					state_d = (plane_q == PLANE_LAST) ? ST_OUT_A : ST_PLANE;
				end else if (!ina && !inb) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SEL;
				end
			end
			ST_SEL: begin
				if (j_q == 2'd3) begin
					state_d = ST_WR;
				end else if (j_q != axis) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: if (cnt_q == CNT_LAST) state_d = ST_DIV;
			ST_DIV: if (cnt_q == CNT_LAST) state_d = ST_RND;
			ST_RND: state_d = ST_SEL;
			ST_WR: state_d = (plane_q == PLANE_LAST) ? ST_OUT_A : ST_PLANE;
			ST_OUT_A: begin
				pt.valid = 1'b1;
				if (pt.ready) state_d = ST_OUT_B;
			end
			ST_OUT_B: begin
				pt.valid = 1'b1;
				if (pt.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign pt.out_x = (state_q == ST_OUT_B) ? OUT_BITS'(b_q[0]) : OUT_BITS'(a_q[0]);
	assign pt.out_y = (state_q == ST_OUT_B) ? OUT_BITS'(b_q[1]) : OUT_BITS'(a_q[1]);
	assign pt.out_z = (state_q == ST_OUT_B) ? OUT_BITS'(b_q[2]) : OUT_BITS'(a_q[2]);
	assign pt.segment_end = (state_q == ST_OUT_B);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lines_mode_q <= 1'b1;
			have_prev_q <= 1'b0;
			prev_q[0] <= '0;
			prev_q[1] <= '0;
			prev_q[2] <= '0;
		end else begin
			state_q <= state_d;
			if (lines_mode_we) lines_mode_q <= lines_mode_wdata;
			if (accept) begin
				have_prev_q <= 1'b1;
				prev_q[0] <= vtx.vert_x;
				prev_q[1] <= vtx.vert_y;
				prev_q[2] <= vtx.vert_z;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				a_q <= prev_q;
				b_q[0] <= vtx.vert_x;
				b_q[1] <= vtx.vert_y;
				b_q[2] <= vtx.vert_z;
				plane_q <= '0;
			end
			ST_PLANE: begin
				ina_q <= ina;
				num_q <= DW'(n0);
				den_q <= DW'(d0);
				j_q <= '0;
				if (ina && inb) plane_q <= plane_q + 3'd1;
			end
			ST_SEL: begin
				dneg_q <= dj < 0;
				mcand_q <= (dj < 0) ? DW'(-dj) : DW'(dj);
				nsh_q <= num_q;
				prod_q <= '0;
				cnt_q <= '0;
				if (j_q == axis) j_q <= j_q + 2'd1;
			end
			ST_MUL: begin
				prod_q <= prod_nx;
				nsh_q <= {nsh_q[DW-2:0], 1'b0};
				cnt_q <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
				rem_q <= {1'b0, prod_nx[PW-1:DW]};
				low_q <= prod_nx[DW-1:0];
			end
			ST_DIV: begin
				cnt_q <= cnt_q + 1'b1;
				if (trial >= (DW+1)'(den_q)) begin
					rem_q <= trial - (DW+1)'(den_q);
					low_q <= {low_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					low_q <= {low_q[DW-2:0], 1'b0};
				end
			end
			ST_RND: begin
				case (j_q)
					2'd0: tmp_q[0] <= COORD_BITS'(res_j);
					2'd1: tmp_q[1] <= COORD_BITS'(res_j);
					default: tmp_q[2] <= COORD_BITS'(res_j);
				endcase
				j_q <= j_q + 2'd1;
			end
			ST_WR: begin
				for (int k = 0; k < 3; k++) begin
					if (ina_q) b_q[k] <= (2'(k) == axis) ? bound : tmp_q[k];
					else a_q[k] <= (2'(k) == axis) ? bound : tmp_q[k];
				end
				plane_q <= plane_q + 3'd1;
			end
			default: ;
		endcase
	end

	`ASSERT_CLK(a_end_follows, clk, arst_n, pt.valid && pt.ready && !pt.segment_end |=> pt.valid && pt.segment_end)
	`ASSERT_NEVER(a_one_at_a_time, clk, arst_n, vtx.ready && pt.valid)
	`ASSERT_CLK(a_rem_below_den, clk, arst_n, state_q == ST_DIV |-> rem_q < (DW+1)'(den_q))
endmodule
